[sv/button_debounce_duration_top_assert.svh]
// Assertion macros for the button debounce duration checker.
// Each macro expects a clock named clk in scope; all but BDD_ASSERT_NEXT_ALWAYS also use an active-low reset rst_n.
`ifndef BUTTON_DEBOUNCE_DURATION_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_DURATION_TOP_ASSERT_SVH

// Implication in the same cycle, skipped while in reset.
`define BDD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdd assertion failed");

// Implication checked in the next cycle, skipped while in reset.
`define BDD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdd assertion failed");

// Implication checked in the next cycle, checked during reset too.
`define BDD_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bdd assertion failed");

`endif

[sv/bdd_pkg.sv]
// Package for the button debounce duration block: widths, modes, register
// indexes and the debounce state struct. Depends on nothing.
package bdd_pkg;

  localparam int TIME_BITS  = 32;
  localparam int DUR_BITS   = 32;
  localparam int NOW_BITS   = 32;
  localparam int DELAY_BITS = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 1'd1;

  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 16'd50;

  typedef enum logic [1:0] {
    MODE_RELEASE = 2'd0,
    MODE_PRESS   = 2'd1,
    MODE_HOLD    = 2'd2
  } bdd_mode_t;

  typedef struct packed {
    logic                 level;
    logic [TIME_BITS-1:0] change_time;
    logic                 timing;
  } bdd_state_t;

endpackage

[sv/bdd_step.sv]
// Debounce and duration step for one sample: next state and reported duration.
// Depends on bdd_pkg.
module bdd_step (
  input  bdd_pkg::bdd_mode_t              mode,
  input  logic [bdd_pkg::DELAY_BITS-1:0]  delay,
  input  bdd_pkg::bdd_state_t             state,
  input  logic                            pin_level,
  input  logic [bdd_pkg::NOW_BITS-1:0]    now_ms,
  output bdd_pkg::bdd_state_t             state_nxt,
  output logic [bdd_pkg::DUR_BITS-1:0]    duration
);
  import bdd_pkg::*;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic                 pass;

  assign now_t   = TIME_BITS'(now_ms);
  assign elapsed = now_t - state.change_time;
  // Look only at a level change or while a press is being timed, then wait out the delay.
  assign pass    = ((pin_level != state.level) || state.timing) &&
                   (elapsed >= TIME_BITS'(delay));

  always_comb begin
    state_nxt = state;
    duration  = '0;
    if (pass) begin
      case (mode)
        MODE_RELEASE: begin
          if (pin_level) duration = DUR_BITS'(elapsed);
          state_nxt.level       = pin_level;
          state_nxt.change_time = now_t;
        end
        MODE_PRESS: begin
          if (!pin_level) duration = DUR_BITS'(elapsed);
          state_nxt.level       = pin_level;
          state_nxt.change_time = now_t;
        end
        MODE_HOLD: begin
          if (!pin_level) begin
            // Start timing on the first debounced low, then report the running length.
            if (!state.timing) begin
              state_nxt.change_time = now_t;
              state_nxt.timing      = 1'b1;
            end else begin
              duration = DUR_BITS'(elapsed);
            end
          end else begin
            state_nxt.level       = pin_level;
            state_nxt.change_time = now_t;
            state_nxt.timing      = 1'b0;
          end
        end
        default: begin
          state_nxt = state;
        end
      endcase
    end
  end

endmodule

[sv/button_debounce_duration_top.sv]
// An accepted item is registered in the input stage, then in the result stage, where its duration shows.
// Throughput: one item per cycle unless the output stalls; the step logic is combinational.
// While a result waits, the input stage holds its item and takes a new one only when empty.
// Reset (rst_n low, synchronous): stages empty, mode 0, delay 50, level released,
// change time zero, timing off.
module button_debounce_duration_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_pin_level,
  input  logic [bdd_pkg::NOW_BITS-1:0]    in_now_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bdd_pkg::DUR_BITS-1:0]    out_duration,
  input  logic                            cfg_we,
  input  logic [bdd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bdd_pkg::*;

  // Configuration registers.
  bdd_mode_t             mode_r;
  logic [DELAY_BITS-1:0] delay_r;

  // Debounce state, updated as an item leaves the input stage.
  bdd_state_t state_r;
  bdd_state_t state_nxt;

  // Input stage.
  logic                s1_valid_r;
  logic                s1_level_r;
  logic [NOW_BITS-1:0] s1_now_r;

  // Result stage.
  logic                out_valid_r;
  logic [DUR_BITS-1:0] out_duration_r;
  logic [DUR_BITS-1:0] duration_nxt;

  logic out_free;
  logic s1_adv;

  // The result slot is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || s1_adv;

  assign out_valid    = out_valid_r;
  assign out_duration = out_duration_r;

  // Write configuration; the user must write only while the block is idle, as the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RELEASE;
      delay_r <= DELAY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  mode_r  <= bdd_mode_t'(cfg_wdata[1:0]);
        REG_DELAY: delay_r <= cfg_wdata[DELAY_BITS-1:0];
        default:   mode_r  <= mode_r;
      endcase
    end
  end

  bdd_step u_step (
    .mode      (mode_r),
    .delay     (delay_r),
    .state     (state_r),
    .pin_level (s1_level_r),
    .now_ms    (s1_now_r),
    .state_nxt (state_nxt),
    .duration  (duration_nxt)
  );

  // Capture the item; hold it while the result slot is busy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_level_r <= in_pin_level;
      s1_now_r   <= in_now_ms;
    end
  end

  // Advance the state only when the item moves on, so each item updates it once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.level       <= 1'b1;
      state_r.change_time <= '0;
      state_r.timing      <= 1'b0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_duration_r <= duration_nxt;
    end
  end

endmodule

[sv/bdd_checker.sv]
// Port-level checker for button_debounce_duration_top, attached by bind.
// Depends on bdd_pkg and button_debounce_duration_top_assert.svh.
`include "button_debounce_duration_top_assert.svh"

module bdd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bdd_pkg::DUR_BITS-1:0] out_duration
);
  import bdd_pkg::*;

  // Reset empties the result slot.
  `BDD_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid)
  // A stalled result stays offered with the same value.
  `BDD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_duration))
  // With no result waiting, the block always takes an item.
  `BDD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
  // An accepted item, held in the input stage, reaches the output once the output drains.
  `BDD_ASSERT_NEXT(a_latency, (in_valid && in_ready) ##1 out_ready, out_valid)

endmodule

bind button_debounce_duration_top bdd_checker u_bdd_checker (.*);
